### rtl/rfc_pkg.sv
package rfc_pkg;

	// Command codes carried in the request transaction.
	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_ADD    = 3'd1;
	localparam logic [2:0] CMD_FOLLOW = 3'd2;
	localparam logic [2:0] CMD_STOP   = 3'd3;
	localparam logic [2:0] CMD_NEXT   = 3'd4;
	localparam logic [2:0] CMD_PREV   = 3'd5;

	// Request transaction.
	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] player_key;
	} req_item_t;

	// Response transaction.
	typedef struct packed {
		logic        accepted;
		logic [31:0] answer_id;
		logic        is_following;
		logic        slot_valid;
		logic [4:0]  slot_index;
		logic [5:0]  fill_count;
	} rsp_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic conclude;
		logic out_load;
	} rfc_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic exhausted;
	} rfc_stat_t;

endpackage

### rtl/rfc_ctrl.sv
module rfc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  rfc_pkg::rfc_stat_t stat,
	output rfc_pkg::rfc_ctrl_t ctrl
);
	import rfc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   rsp_valid_q;

	// Commands issued in each state.
	always_comb begin
		ctrl.load     = (state_q == ST_IDLE) && req_valid;
		ctrl.exec     = (state_q == ST_EXEC);
		ctrl.conclude = (state_q == ST_SCAN) && (stat.hit || stat.exhausted);
		ctrl.out_load = (state_q == ST_RESULT) && (!rsp_valid_q || rsp_ready);
	end

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_next = ST_EXEC;
			end
			ST_EXEC: begin
				state_next = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.hit || stat.exhausted) state_next = ST_RESULT;
			end
			ST_RESULT: begin
				if (!rsp_valid_q || rsp_ready) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State and response valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ctrl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

### rtl/rfc_datapath.sv
module rfc_datapath #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rfc_pkg::req_item_t req,
	input  rfc_pkg::rfc_ctrl_t ctrl,
	output rfc_pkg::rfc_stat_t stat,
	output rfc_pkg::rsp_item_t rsp
);
	import rfc_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	// Table state.
	logic [31:0]          id_mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] marks_q;
	logic [CW-1:0]        count_q;
	logic                 cur_valid_q;
	logic [IW-1:0]        cursor_q;
	logic [31:0]          target_q;
	logic                 follow_q;

	// Captured transaction and per-transaction result.
	logic [2:0]  cmd_q;
	logic [31:0] key_q;
	logic        acc_q;
	logic [31:0] cyc_ans_q;

	// Scan engine: issue stage and compare stage.
	logic [IW-1:0] idx_q;
	logic [CW-1:0] left_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [31:0]   rd_s1;

	logic          fwd;
	logic          is_cycle;
	logic          mark_s1;
	logic          hit;
	logic          add_ok;
	logic [IW-1:0] cycle_start;
	rsp_item_t     rsp_next;

	// One step around the first n entries, with wrap.
	function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] idx, input logic dir_fwd,
		input logic [CW-1:0] n);
		logic [IW-1:0] res;
		if (dir_fwd) begin
			res = ((CW'(idx) + CW'(1)) >= n) ? '0 : idx + IW'(1);
		end else begin
			res = (idx == '0) ? IW'(n - CW'(1)) : idx - IW'(1);
		end
		return res;
	endfunction

	assign fwd      = (cmd_q != CMD_PREV);
	assign is_cycle = (cmd_q == CMD_NEXT) || (cmd_q == CMD_PREV);
	assign add_ok   = (key_q != 32'd0) && (count_q < CW'(MAX_ENTRIES));
	assign mark_s1  = marks_q[idx_s1];

	// Starting entry of a cycle scan.
	always_comb begin
		if (cur_valid_q && (CW'(cursor_q) < count_q)) begin
			cycle_start = step_idx(cursor_q, fwd, count_q);
		end else if (fwd) begin
			cycle_start = '0;
		end else begin
			cycle_start = IW'(count_q - CW'(1));
		end
	end

	// Match test on the entry read in the previous cycle.
	always_comb begin
		case (cmd_q)
			CMD_ADD:    hit = vld_s1 && (rd_s1 == key_q);
			CMD_FOLLOW: hit = vld_s1 && mark_s1 && (rd_s1 == key_q);
			CMD_NEXT:   hit = vld_s1 && mark_s1;
			CMD_PREV:   hit = vld_s1 && mark_s1;
			default:    hit = 1'b0;
		endcase
	end

	assign stat.hit       = hit;
	assign stat.exhausted = (left_q == '0) && !vld_s1;

	// Table state and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q     <= '0;
			count_q     <= '0;
			cur_valid_q <= 1'b0;
			cursor_q    <= '0;
			target_q    <= '0;
			follow_q    <= 1'b0;
			left_q      <= '0;
			vld_s1      <= 1'b0;
		end else begin
			// Scan issue and compare stage.
			if (ctrl.exec) begin
				vld_s1 <= 1'b0;
				case (cmd_q)
					CMD_ADD:    left_q <= add_ok ? count_q : '0;
					CMD_FOLLOW: left_q <= count_q;
					CMD_NEXT:   left_q <= count_q;
					CMD_PREV:   left_q <= count_q;
					default:    left_q <= '0;
				endcase
			end else if (hit) begin
				left_q <= '0;
				vld_s1 <= 1'b0;
			end else begin
				vld_s1 <= (left_q != '0);
				if (left_q != '0) left_q <= left_q - CW'(1);
			end

			// Immediate part of each command.
			if (ctrl.exec) begin
				case (cmd_q)
					CMD_CLEAR: begin
						marks_q     <= '0;
						count_q     <= '0;
						cur_valid_q <= 1'b0;
						cursor_q    <= '0;
					end
					CMD_FOLLOW: begin
						target_q    <= key_q;
						follow_q    <= 1'b1;
						cur_valid_q <= 1'b0;
						cursor_q    <= '0;
					end
					CMD_STOP: begin
						target_q    <= '0;
						follow_q    <= 1'b0;
						cur_valid_q <= 1'b0;
						cursor_q    <= '0;
					end
					default: begin
					end
				endcase
			end

			// Outcome of the scan.
			if (ctrl.conclude) begin
				if (hit) begin
					case (cmd_q)
						CMD_ADD: marks_q[idx_s1] <= 1'b1;
						CMD_FOLLOW: begin
							cur_valid_q <= 1'b1;
							cursor_q    <= idx_s1;
						end
						CMD_NEXT, CMD_PREV: begin
							target_q    <= rd_s1;
							follow_q    <= 1'b1;
							cur_valid_q <= 1'b1;
							cursor_q    <= idx_s1;
						end
						default: begin
						end
					endcase
				end else if ((cmd_q == CMD_ADD) && acc_q) begin
					marks_q[IW'(count_q)] <= 1'b1;
					count_q               <= count_q + CW'(1);
				end
			end
		end
	end

	// Captured transaction, scan addresses and per-transaction result.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q     <= req.command;
			key_q     <= req.player_key;
			acc_q     <= 1'b1;
			cyc_ans_q <= '0;
		end
		if (ctrl.exec) begin
			idx_q <= is_cycle ? cycle_start : '0;
			if ((cmd_q == CMD_ADD) && !add_ok) acc_q <= 1'b0;
		end else begin
			idx_q <= step_idx(idx_q, fwd, count_q);
		end
		if (ctrl.conclude && is_cycle) begin
			if (hit) begin
				cyc_ans_q <= rd_s1;
			end else begin
				acc_q     <= 1'b0;
				cyc_ans_q <= '0;
			end
		end
		idx_s1 <= idx_q;
	end

	// Id memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctrl.conclude && !hit && (cmd_q == CMD_ADD) && acc_q) begin
			id_mem[IW'(count_q)] <= key_q;
		end
		rd_s1 <= id_mem[idx_q];
	end

	// Response assembly and response register.
	always_comb begin
		rsp_next.accepted     = acc_q;
		rsp_next.answer_id    = is_cycle ? cyc_ans_q : target_q;
		rsp_next.is_following = follow_q;
		rsp_next.slot_valid   = cur_valid_q;
		rsp_next.slot_index   = cur_valid_q ? 5'(cursor_q) : 5'd0;
		rsp_next.fill_count   = 6'(count_q);
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) rsp <= rsp_next;
	end

endmodule

### rtl/roster_follow_cycler.sv
// Channel   Handshake             Payload
// request   req_valid/req_ready   req (req_item_t: command, player_key)
// response  rsp_valid/rsp_ready   rsp (rsp_item_t: accepted ... fill_count)
//
// From acceptance to response a transaction passes an execute state, a scan of up to
// fill_count entries through the id memory's single read port at one entry per cycle
// behind a registered read and a compare stage that sees the scan end, and the load
// of the response register; commands without a lookup scan nothing. One transaction
// is in work at a time; the next request is taken in the cycle after the response
// register is loaded. That register holds a finished result while the next request is
// taken. Reset clears table marks, fill count, cursor and target; no clearing pass.
module roster_follow_cycler #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  rfc_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rfc_pkg::rsp_item_t rsp
);
	import rfc_pkg::*;

	rfc_ctrl_t ctrl;
	rfc_stat_t stat;

	// Sequencer.
	rfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// Table, scan engine and response register.
	rfc_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctrl   (ctrl),
		.stat   (stat),
		.rsp    (rsp)
	);

	// A waiting response is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!rsp_valid || rsp_ready))
		else $error("response register loaded while a response was waiting");

	// Only one transaction is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another transaction was in work");

	// The cursor always points inside the filled part of the table.
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.slot_valid) |-> (rsp.slot_index < rsp.fill_count))
		else $error("cursor beyond fill count");

	// The fill count never passes the table size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp.fill_count) <= 32'(MAX_ENTRIES)))
		else $error("fill count above table size");

endmodule
